### design/hash_table_linear_probe_insert_unit_macros.svh
// Assertion macros for the hash table insert unit checker.
// Depends on clk_i and rst_ni being visible where the macros are used.
`ifndef HASH_TABLE_LINEAR_PROBE_INSERT_UNIT_MACROS_SVH
`define HASH_TABLE_LINEAR_PROBE_INSERT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define HTLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset
`define HTLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/htlp_pkg.sv
// Shared types and constants of the hash table insert unit.
// No dependencies.
package htlp_pkg;

  // splitmix64 finaliser constants
  localparam logic [63:0] GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MUL_A = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MUL_B = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned SHIFT_A = 30;
  localparam int unsigned SHIFT_B = 27;
  localparam int unsigned SHIFT_C = 31;

  // Configuration register
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [CFG_W-1:0] MIN_BITS = 5'd2;

  // Result fields
  localparam int unsigned SLOT_W = 16;
  localparam int unsigned ENTRY_W = 16;
  localparam logic [ENTRY_W-1:0] COUNTER_MAX = 16'hFFFF;

  // Occupancy tags: zero marks an empty slot
  localparam int unsigned EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = 8'hFF;

  // Queue between hashing front and probing back
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic               valid;
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] entry_number;
    logic               table_full;
  } result_t;

endpackage

### design/htlp_front.sv
// Front end: takes insert transactions and hashes the key to a start slot.
// Depends on htlp_pkg; feeds htlp_fifo.
module htlp_front import htlp_pkg::*; #(
  parameter int TABLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [63:0]           key_i,
  input  logic                  first_i,
  input  logic                  hold_i,
  input  logic [TABLE_BITS-1:0] mask_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output logic [TABLE_BITS:0]   q_data_o,
  output logic                  busy_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_MUL  = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  // Partial product steps of one 64 x 64 multiply
  localparam logic [1:0] STEP_LO  = 2'd0;
  localparam logic [1:0] STEP_XHI = 2'd1;
  localparam logic [1:0] STEP_CHI = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [1:0]  step_q, step_d;
  logic        round_q, round_d;
  logic [63:0] v_q, v_d;
  logic [63:0] acc_q, acc_d;
  logic        first_q, first_d;

  logic [63:0] mix_x, mix_c, prod, acc_sum, fin;
  logic [31:0] mul_a, mul_b;
  logic        accept;

  assign busy_o = (state_q != F_IDLE) || hold_i;
  assign accept = start_i && !busy_o;

  // Select operands of the shared multiplier
  assign mix_x = round_q ? (v_q ^ (v_q >> SHIFT_B)) : (v_q ^ (v_q >> SHIFT_A));
  assign mix_c = round_q ? MUL_B : MUL_A;
  assign mul_a = (step_q == STEP_XHI) ? mix_x[63:32] : mix_x[31:0];
  assign mul_b = (step_q == STEP_CHI) ? mix_c[63:32] : mix_c[31:0];
  assign prod    = 64'(mul_a) * 64'(mul_b);
  assign acc_sum = acc_q + {prod[31:0], 32'h0};

  // Final xor-shift and mask to the active table
  assign fin      = v_q ^ (v_q >> SHIFT_C);
  assign q_data_o = {fin[TABLE_BITS-1:0] & mask_i, first_q};

  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    round_d  = round_q;
    v_d      = v_q;
    acc_d    = acc_q;
    first_d  = first_q;
    q_push_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          v_d     = key_i + GAMMA;
          first_d = first_i;
          step_d  = STEP_LO;
          round_d = 1'b0;
          state_d = F_MUL;
        end
      end
      F_MUL: begin
        case (step_q)
          STEP_LO: begin
            acc_d  = prod;
            step_d = STEP_XHI;
          end
          STEP_XHI: begin
            acc_d  = acc_sum;
            step_d = STEP_CHI;
          end
          default: begin
            v_d    = acc_sum;
            step_d = STEP_LO;
            if (round_q) begin
              state_d = F_PUSH;
            end else begin
              round_d = 1'b1;
            end
          end
        endcase
      end
      F_PUSH: begin
        // Hand the start slot on once the queue has room
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      step_q  <= STEP_LO;
      round_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q     <= v_d;
    acc_q   <= acc_d;
    first_q <= first_d;
  end

endmodule

### design/htlp_fifo.sv
// Short queue of hashed transactions between front and back.
// Depends on htlp_pkg for its depth.
module htlp_fifo import htlp_pkg::*; #(
  parameter int WIDTH = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (PTR_W + 1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### design/htlp_back.sv
// Back end: probes the slot memory linearly and claims the first free slot, or reports the table full.
// Depends on htlp_pkg; fed by htlp_fifo.
module htlp_back import htlp_pkg::*; #(
  parameter int TABLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_empty_i,
  input  logic [TABLE_BITS:0]   q_data_i,
  output logic                  q_pop_o,
  input  logic [TABLE_BITS-1:0] mask_i,
  output logic                  clear_o,
  output result_t               res_o
);

  localparam int DEPTH = 1 << TABLE_BITS;

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_PROBE = 2'd2;

  // Occupancy tags: a slot is taken when its tag equals the current epoch
  logic [EPOCH_W-1:0] tag_mem [DEPTH];
  logic [EPOCH_W-1:0] rdata_q;

  logic [1:0]            state_q, state_d;
  logic [TABLE_BITS-1:0] clr_addr_q, clr_addr_d;
  logic [EPOCH_W-1:0]    epoch_q, epoch_d;
  logic [ENTRY_W-1:0]    cnt_q, cnt_d;
  logic [TABLE_BITS-1:0] cmp_pos_q, cmp_pos_d;
  logic [TABLE_BITS-1:0] rd_pos_q, rd_pos_d;
  logic [TABLE_BITS-1:0] tries_q, tries_d;
  logic                  res_valid_q, res_valid_d;
  logic [SLOT_W-1:0]     res_slot_q, res_slot_d;
  logic [ENTRY_W-1:0]    res_entry_q, res_entry_d;
  logic                  res_full_q, res_full_d;

  logic                  mem_we;
  logic [TABLE_BITS-1:0] mem_waddr, mem_raddr;
  logic [EPOCH_W-1:0]    mem_wdata;
  logic [TABLE_BITS-1:0] q_pos;
  logic                  q_first;
  logic                  occupied;

  assign q_pos    = q_data_i[TABLE_BITS:1];
  assign q_first  = q_data_i[0];
  assign occupied = (rdata_q == epoch_q);
  assign clear_o  = (state_q == B_CLEAR);

  assign res_o.valid        = res_valid_q;
  assign res_o.slot         = res_slot_q;
  assign res_o.entry_number = res_entry_q;
  assign res_o.table_full   = res_full_q;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    epoch_d     = epoch_q;
    cnt_d       = cnt_q;
    cmp_pos_d   = cmp_pos_q;
    rd_pos_d    = rd_pos_q;
    tries_d     = tries_q;
    res_valid_d = 1'b0;
    res_slot_d  = res_slot_q;
    res_entry_d = res_entry_q;
    res_full_d  = res_full_q;
    q_pop_o     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cmp_pos_q;
    mem_wdata   = epoch_q;
    mem_raddr   = rd_pos_q;
    case (state_q)
      B_CLEAR: begin
        // Sweep every slot back to empty
        mem_we     = 1'b1;
        mem_waddr  = clr_addr_q;
        mem_wdata  = '0;
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == '1) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        mem_raddr = q_pos;
        if (!q_empty_i) begin
          if (q_first && (epoch_q == EPOCH_MAX)) begin
            // Tags exhausted: wipe the store, the head transaction waits
            state_d    = B_CLEAR;
            clr_addr_d = '0;
            epoch_d    = '0;
          end else begin
            q_pop_o = 1'b1;
            if (q_first) begin
              cnt_d   = '0;
              epoch_d = epoch_q + 1'b1;
            end
            if (!q_first && (cnt_q == COUNTER_MAX)) begin
              // No entry number left: report as full
              res_valid_d = 1'b1;
              res_slot_d  = '0;
              res_entry_d = '0;
              res_full_d  = 1'b1;
            end else begin
              cmp_pos_d = q_pos;
              rd_pos_d  = (q_pos + 1'b1) & mask_i;
              tries_d   = '0;
              state_d   = B_PROBE;
            end
          end
        end
      end
      B_PROBE: begin
        if (!occupied) begin
          // Claim the free slot and drop the read still in flight
          mem_we      = 1'b1;
          mem_waddr   = cmp_pos_q;
          mem_wdata   = epoch_q;
          cnt_d       = cnt_q + 1'b1;
          res_valid_d = 1'b1;
          res_slot_d  = SLOT_W'(cmp_pos_q);
          res_entry_d = cnt_q + 1'b1;
          res_full_d  = 1'b0;
          state_d     = B_IDLE;
        end else if (tries_q == mask_i) begin
          res_valid_d = 1'b1;
          res_slot_d  = '0;
          res_entry_d = '0;
          res_full_d  = 1'b1;
          state_d     = B_IDLE;
        end else begin
          // Advance one slot, with the next read already issued
          cmp_pos_d = rd_pos_q;
          rd_pos_d  = (rd_pos_q + 1'b1) & mask_i;
          tries_d   = tries_q + 1'b1;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_addr_q  <= '0;
      epoch_q     <= {{(EPOCH_W-1){1'b0}}, 1'b1};
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      epoch_q     <= epoch_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_pos_q   <= cmp_pos_d;
    rd_pos_q    <= rd_pos_d;
    tries_q     <= tries_d;
    res_slot_q  <= res_slot_d;
    res_entry_q <= res_entry_d;
    res_full_q  <= res_full_d;
  end

  // Slot tag memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= tag_mem[mem_raddr];
  end

endmodule

### design/hash_table_linear_probe_insert_unit.sv
// Top level of the hash table insert unit: config register, front, queue, back.
// Depends on htlp_pkg, htlp_front, htlp_fifo and htlp_back.
//
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+-------------------------------------
// insert    | in        | start high, busy low    | key_i, first_of_table_i
// result    | out       | result_valid_o, 1 cycle | slot_o, entry_number_o, table_full_o
// config    | in        | cfg_we_i, no wait       | cfg_wdata_i (table_bits)
//
// Hashing: one shared 32 x 32 multiplier runs three passes per 64-bit product; the
// front takes no new key until it has pushed the last. The back end pops from the
// queue, then probes one slot per cycle on the single memory read port; the result
// is registered. After reset a clearing pass over all 2^TABLE_BITS slots holds
// busy high; it runs again at every 255th table restart. Results cannot be stalled.
module hash_table_linear_probe_insert_unit import htlp_pkg::*; #(
  parameter int TABLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [63:0]        key_i,
  input  logic               first_of_table_i,
  output logic               result_valid_o,
  output logic [SLOT_W-1:0]  slot_o,
  output logic [ENTRY_W-1:0] entry_number_o,
  output logic               table_full_o,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i
);

  localparam logic [CFG_W-1:0] TB_MAX = CFG_W'(TABLE_BITS);

  logic [CFG_W-1:0]      table_bits_q;
  logic [CFG_W-1:0]      act_bits;
  logic [TABLE_BITS-1:0] mask;
  logic                  q_push, q_pop, q_full, q_empty, clearing;
  logic [TABLE_BITS:0]   q_wdata, q_rdata;
  result_t               res;

  // Hold the table size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_bits_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      table_bits_q <= cfg_wdata_i;
    end
  end

  // Clamp the size and build the slot mask
  always_comb begin
    if (table_bits_q < MIN_BITS) begin
      act_bits = MIN_BITS;
    end else if (table_bits_q > TB_MAX) begin
      act_bits = TB_MAX;
    end else begin
      act_bits = table_bits_q;
    end
    for (int i = 0; i < TABLE_BITS; i++) begin
      mask[i] = (CFG_W'(i) < act_bits);
    end
  end

  htlp_front #(
    .TABLE_BITS(TABLE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .key_i   (key_i),
    .first_i (first_of_table_i),
    .hold_i  (clearing),
    .mask_i  (mask),
    .q_full_i(q_full),
    .q_push_o(q_push),
    .q_data_o(q_wdata),
    .busy_o  (busy)
  );

  htlp_fifo #(
    .WIDTH(TABLE_BITS + 1)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  htlp_back #(
    .TABLE_BITS(TABLE_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_data_i (q_rdata),
    .q_pop_o  (q_pop),
    .mask_i   (mask),
    .clear_o  (clearing),
    .res_o    (res)
  );

  assign result_valid_o = res.valid;
  assign slot_o         = res.slot;
  assign entry_number_o = res.entry_number;
  assign table_full_o   = res.table_full;

endmodule

### design/htlp_checker.sv
// Port-level checker for the hash table insert unit, bound to the top level.
// Depends on htlp_pkg and the assertion macros header.
`include "hash_table_linear_probe_insert_unit_macros.svh"

module htlp_checker import htlp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input logic [SLOT_W-1:0]  slot_o,
  input logic [ENTRY_W-1:0] entry_number_o,
  input logic               table_full_o
);

  // A full result writes nothing and reports zero fields
  `HTLP_ASSERT_IMP(a_full_zero, result_valid_o && table_full_o,
    (slot_o == '0) && (entry_number_o == '0), "full result with nonzero slot or entry number")

  // A stored entry number is never zero
  `HTLP_ASSERT_IMP(a_entry_nonzero, result_valid_o && !table_full_o,
    entry_number_o != '0, "inserted result with entry number zero")

  // Hashing keeps the unit busy straight after a transaction is taken
  `HTLP_ASSERT_NXT(a_busy_after_accept, start && !busy, busy,
    "busy not raised after accepting a transaction")

  // The clearing pass holds busy as reset is released
  `HTLP_ASSERT_IMP(a_busy_out_of_reset, $rose(rst_ni), busy,
    "busy low while the store is being cleared")

endmodule

bind hash_table_linear_probe_insert_unit htlp_checker u_checker (.*);

### verif/hash_table_linear_probe_insert_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for hash_table_linear_probe_insert_unit: drives inserts and table sizes.
// Depends on htlp_pkg and the unit's RTL; a shadow probe table predicts every placement.
module hash_table_linear_probe_insert_unit_tb import htlp_pkg::*;;

  localparam int TABLE_BITS = 16;
  localparam int STORE_DEPTH = 1 << TABLE_BITS;
  localparam logic [CFG_W-1:0] BITS_AT_RESET = 5'd16;
  localparam logic [ENTRY_W-1:0] LAST_ENTRY = 16'hFFFF;

  // splitmix64 finaliser, kept local to the bench
  localparam logic [63:0] MIX_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_2 = 64'h94D0_49BB_1331_11EB;
  localparam int unsigned XS_FIRST = 30;
  localparam int unsigned XS_SECOND = 27;
  localparam int unsigned XS_LAST = 31;

  typedef struct {
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] entry_number;
    logic               table_full;
  } placement_t;

  // Shadow of the probe table and the queue of placements still owed by the unit
  class probe_table_scoreboard;
    logic [ENTRY_W-1:0] slot_entries [STORE_DEPTH];
    logic [ENTRY_W-1:0] entry_count;
    logic [CFG_W-1:0]   table_bits;
    placement_t         pending_placements [$];
    int unsigned        mismatches, inserts, full_results, cfg_writes, restarts, checked;

    function new();
      foreach (slot_entries[i]) slot_entries[i] = '0;
      entry_count = '0;
      table_bits = BITS_AT_RESET;
    endfunction

    function int unsigned effective_bits();
      if (table_bits < 2) return 2;
      if (table_bits > TABLE_BITS) return TABLE_BITS;
      return 32'(table_bits);
    endfunction

    function logic [63:0] mix_key(logic [63:0] key);
      logic [63:0] v;
      v = key + MIX_GAMMA;
      v = (v ^ (v >> XS_FIRST)) * MIX_MUL_1;
      v = (v ^ (v >> XS_SECOND)) * MIX_MUL_2;
      return v ^ (v >> XS_LAST);
    endfunction

    function void set_table_bits(logic [CFG_W-1:0] value);
      table_bits = value;
      cfg_writes++;
    endfunction

    // Probe from the hashed slot, wrapping, and claim the first empty one
    function void place_key(logic [63:0] key, logic first);
      placement_t  p;
      logic [63:0] h;
      int unsigned size, mask, pos, tries;
      bit          found;
      inserts++;
      if (first) begin
        restarts++;
        foreach (slot_entries[i]) slot_entries[i] = '0;
        entry_count = '0;
      end
      size = 1 << effective_bits();
      mask = size - 1;
      h = mix_key(key);
      pos = h[31:0] & mask;
      found = 1'b0;
      if (entry_count != LAST_ENTRY) begin
        for (tries = 0; tries < size && !found; tries++) begin
          if (slot_entries[pos] == '0) found = 1'b1;
          else pos = (pos + 1) & mask;
        end
      end
      if (found) begin
        entry_count++;
        slot_entries[pos] = entry_count;
        p.slot = pos[SLOT_W-1:0];
        p.entry_number = entry_count;
        p.table_full = 1'b0;
      end else begin
        p.slot = '0;
        p.entry_number = '0;
        p.table_full = 1'b1;
        full_results++;
      end
      pending_placements = {pending_placements, p};
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Compare one result transaction with the oldest owed placement
    task check_result(logic [SLOT_W-1:0] slot, logic [ENTRY_W-1:0] entry, logic full);
      placement_t want;
      if (pending_placements.size() == 0) begin
        flag_mismatch($sformatf("unexpected result slot %0d entry %0d full %0b",
                                slot, entry, full));
        return;
      end
      want = pending_placements.pop_front();
      checked++;
      if (slot !== want.slot)
        flag_mismatch($sformatf("slot %0d, expected %0d", slot, want.slot));
      if (entry !== want.entry_number)
        flag_mismatch($sformatf("entry_number %0d, expected %0d", entry, want.entry_number));
      if (full !== want.table_full)
        flag_mismatch($sformatf("table_full %0b, expected %0b", full, want.table_full));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [63:0]        key_i = '0;
  logic               first_of_table_i = 1'b0;
  logic               result_valid_o;
  logic [SLOT_W-1:0]  slot_o;
  logic [ENTRY_W-1:0] entry_number_o;
  logic               table_full_o;
  logic               cfg_we_i = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata_i = '0;

  probe_table_scoreboard table_sb = new();

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  hash_table_linear_probe_insert_unit #(
    .TABLE_BITS(TABLE_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .key_i           (key_i),
    .first_of_table_i(first_of_table_i),
    .result_valid_o  (result_valid_o),
    .slot_o          (slot_o),
    .entry_number_o  (entry_number_o),
    .table_full_o    (table_full_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Observe register writes, results and accepted transactions; check before predicting
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) table_sb.set_table_bits(cfg_wdata_i);
      if (result_valid_o) table_sb.check_result(slot_o, entry_number_o, table_full_o);
      if (start && !busy) table_sb.place_key(key_i, first_of_table_i);
    end
  end

  // Newton iteration for the inverse of an odd number modulo 2^64
  function automatic logic [63:0] odd_inverse(logic [63:0] a);
    logic [63:0] x;
    x = a;
    repeat (6) x = x * (64'd2 - a * x);
    return x;
  endfunction

  function automatic logic [63:0] undo_xorshift(logic [63:0] y, int unsigned s);
    logic [63:0] v;
    v = y;
    repeat (64 / s + 1) v = y ^ (v >> s);
    return v;
  endfunction

  // Run the finaliser backwards so the key hashes onto the wanted slot
  function automatic logic [63:0] key_for_slot(logic [15:0] slot);
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    v[15:0] = slot;
    v = undo_xorshift(v, XS_LAST) * odd_inverse(MIX_MUL_2);
    v = undo_xorshift(v, XS_SECOND) * odd_inverse(MIX_MUL_1);
    return undo_xorshift(v, XS_FIRST) - MIX_GAMMA;
  endfunction

  // Offer one insert and hold it until the unit takes it; start stays high
  task automatic drive_insert(logic [63:0] key, logic first);
    start <= 1'b1;
    key_i <= key;
    first_of_table_i <= first;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic pause_sender(int unsigned pct);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < pct) ? $urandom_range(1, 24) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop start and wait until every owed result has come back
  task automatic drain_unit();
    start <= 1'b0;
    @(posedge clk_i);
    while (table_sb.pending_placements.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_table_bits(logic [CFG_W-1:0] value);
    drain_unit();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Tables of random length with collisions, repeats and stray restarts
  task automatic run_random_phase(int unsigned pct, int unsigned n_items);
    int unsigned      sent, len, size, pick, i;
    logic [63:0]      key, last_key;
    logic             first;
    logic [CFG_W-1:0] bits;
    sent = 0;
    last_key = '0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) bits = 5'($urandom_range(2, 6));
        else if (pick < 9) bits = 5'($urandom_range(0, 31));
        else bits = 5'd16;
        write_table_bits(bits);
      end
      size = 1 << table_sb.effective_bits();
      if ($urandom_range(0, 1) == 0) len = $urandom_range(1, 2);
      else len = $urandom_range(1, (size + 2 > 24) ? 24 : size + 2);
      for (i = 0; i < len; i++) begin
        if (i == 0) first = ($urandom_range(0, 7) != 0);
        else first = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 9);
        if (pick < 5) key = {$urandom(), $urandom()};
        else if (pick == 7) key = key_for_slot(16'(size - 1));
        else if (pick < 8) key = key_for_slot(16'($urandom_range(0, 3)));
        else key = last_key;
        drive_insert(key, first);
        last_key = key;
        sent++;
        pause_sender(pct);
      end
    end
  endtask

  initial begin
    int unsigned n;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset size: extreme keys, then three keys on the last slot to force a wrap
    drive_insert(64'd0, 1'b0);
    drive_insert({64{1'b1}}, 1'b0);
    repeat (3) drive_insert(key_for_slot(16'hFFFF), 1'b0);

    // Smallest table: one cluster wraps, then the table is full twice
    write_table_bits(5'd2);
    for (n = 0; n < 6; n++) drive_insert(key_for_slot(16'd3), n == 0);

    // Size below the minimum acts as the minimum
    write_table_bits(5'd0);
    for (n = 0; n < 5; n++) drive_insert({$urandom(), $urandom()}, n == 0);

    // Grow without clearing: the old four slots stay taken
    write_table_bits(5'd3);
    repeat (2) drive_insert(key_for_slot(16'd0), 1'b0);
    write_table_bits(5'd1);
    drive_insert(key_for_slot(16'd1), 1'b0);

    // Sizes above the maximum act as the maximum
    write_table_bits(5'd31);
    drive_insert({$urandom(), $urandom()}, 1'b1);
    drive_insert(key_for_slot(16'hFFFF), 1'b0);
    write_table_bits(5'd17);
    drive_insert(key_for_slot(16'h8000), 1'b0);

    // Random tables under different sender gaps
    drain_unit();
    run_random_phase(0, 190);
    run_random_phase(70, 190);
    run_random_phase(28, 190);

    drain_unit();
    repeat (32) @(posedge clk_i);

    $display("Covered %0d inserts (%0d table full), %0d table restarts, %0d size writes.",
             table_sb.inserts, table_sb.full_results, table_sb.restarts, table_sb.cfg_writes);
    $display("Checked %0d placements, %0d mismatches.", table_sb.checked, table_sb.mismatches);
    if (table_sb.mismatches == 0 && table_sb.pending_placements.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("Timed out with %0d placements owed.", table_sb.pending_placements.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/htlp_pkg.sv
design/htlp_front.sv
design/htlp_fifo.sv
design/htlp_back.sv
design/hash_table_linear_probe_insert_unit.sv
design/htlp_checker.sv
verif/hash_table_linear_probe_insert_unit_tb.sv
